>>> hdl/otse_pkg.sv
package otse_pkg;

  localparam int NUM_TICKERS       = 4;
  localparam int ORDERS_PER_TICKER = 8;
  localparam int NUM_ENTRIES       = NUM_TICKERS * ORDERS_PER_TICKER;
  localparam int ADDR_W            = $clog2(NUM_ENTRIES);

  localparam int TICKER_W = 2;
  localparam int SLOT_W   = 3;
  localparam int SEQ_W    = 64;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int IDX_W    = 6;

  localparam logic       CMD_UPDATE   = 1'b0;
  localparam logic       CMD_SNAPSHOT = 1'b1;

  localparam logic [1:0] UPD_ADD    = 2'd0;
  localparam logic [1:0] UPD_MODIFY = 2'd1;
  localparam logic [1:0] UPD_CANCEL = 2'd2;
  localparam logic [1:0] UPD_OTHER  = 2'd3;

  localparam logic [2:0] MSG_START  = 3'd0;
  localparam logic [2:0] MSG_CLEAR  = 3'd1;
  localparam logic [2:0] MSG_ORDER  = 3'd2;
  localparam logic [2:0] MSG_END    = 3'd3;
  localparam logic [2:0] MSG_STATUS = 3'd4;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_DUP     = 3'd1;
  localparam logic [2:0] STS_MISSING = 3'd2;
  localparam logic [2:0] STS_SIDE    = 3'd3;
  localparam logic [2:0] STS_GAP     = 3'd4;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]    msg_index;
    logic [2:0]          msg_kind;
    logic [TICKER_W-1:0] ticker;
    logic [SLOT_W-1:0]   order;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
    logic [SEQ_W-1:0]    last_seq;
    logic [2:0]          status;
    logic                last;
  } result_t;

endpackage

>>> hdl/order_table_snapshot_engine_top.sv
// channel | signals                                                    | accepted when
// in      | in_valid in_ready cmd seq_num update_kind ticker order_slot  | in_valid && in_ready
//         | side price qty                                              |
// out     | out_valid out_ready msg_index msg_kind out_ticker out_order   | out_valid && out_ready
//         | out_side out_price out_qty last_seq status last             |
//
// Update: a table read, then the check and write back, which waits for a free output.
// Snapshot: start, per ticker a clear and a slot scan, then end; the scan reads
// one table entry per cycle, skipped entries included, while no output is held.
// Reset empties the table at once (valid flip-flops) and zeroes the sequence number.
// A held result stalls the engine; the input is taken only when the engine is idle.
module order_table_snapshot_engine_top
  import otse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [SEQ_W-1:0]    seq_num,
  input  logic [1:0]          update_kind,
  input  logic [TICKER_W-1:0] ticker,
  input  logic [SLOT_W-1:0]   order_slot,
  input  logic                side,
  input  logic signed [PRICE_W-1:0] price,
  input  logic [QTY_W-1:0]    qty,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    msg_index,
  output logic [2:0]          msg_kind,
  output logic [TICKER_W-1:0] out_ticker,
  output logic [SLOT_W-1:0]   out_order,
  output logic                out_side,
  output logic signed [PRICE_W-1:0] out_price,
  output logic [QTY_W-1:0]    out_qty,
  output logic [SEQ_W-1:0]    last_seq,
  output logic [2:0]          status,
  output logic                last
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_START, ST_CLEAR, ST_ORDER, ST_END
  } state_t;

  state_t              state;
  result_t             res;
  logic [SEQ_W-1:0]    seq_last;
  logic [NUM_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]    msg_idx;

  logic [SEQ_W-1:0]    upd_seq;
  logic [1:0]          upd_kind;
  logic                upd_side;
  logic [PRICE_W-1:0]  upd_price;
  logic [QTY_W-1:0]    upd_qty;
  logic                upd_in_range;
  logic [ADDR_W-1:0]   upd_addr;

  logic [TICKER_W-1:0] tick_cnt, tick_next;
  logic [SLOT_W-1:0]   slot_cnt, slot_next;

  entry_t              table_mem [NUM_ENTRIES];
  entry_t              rd_data;
  entry_t              wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;

  logic                in_range;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   scan_addr;
  logic [ADDR_W-1:0]   next_addr;
  logic                slot_end, tick_end, scan_adv, out_free;
  logic                upd_ok;
  logic [2:0]          upd_status;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign in_range  = (int'(ticker) < NUM_TICKERS) && (int'(order_slot) < ORDERS_PER_TICKER);
  assign in_addr   = in_range ? ADDR_W'(int'(ticker) * ORDERS_PER_TICKER + int'(order_slot))
                              : '0;
  assign scan_addr = ADDR_W'(int'(tick_cnt) * ORDERS_PER_TICKER + int'(slot_cnt));
  assign next_addr = ADDR_W'(int'(tick_next) * ORDERS_PER_TICKER + int'(slot_next));
  assign slot_end  = (int'(slot_cnt) == ORDERS_PER_TICKER - 1);
  assign tick_end  = (int'(tick_cnt) == NUM_TICKERS - 1);
  assign scan_adv  = !entry_valid[scan_addr] || out_free;
  assign rd_addr   = (state == ST_IDLE) ? in_addr :
                     (state == ST_UPD)  ? upd_addr : next_addr;

  always_comb begin
    tick_next = tick_cnt;
    slot_next = slot_cnt;
    if (state == ST_IDLE) begin
      tick_next = '0;
      slot_next = '0;
    end else if (state == ST_ORDER && scan_adv) begin
      if (slot_end) begin
        slot_next = '0;
        if (!tick_end) begin
          tick_next = tick_cnt + 1'b1;
        end
      end else begin
        slot_next = slot_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    upd_status = STS_OK;
    if (upd_kind != UPD_OTHER) begin
      if (!upd_in_range) begin
        upd_status = STS_MISSING;
      end else if (upd_kind == UPD_ADD) begin
        if (entry_valid[upd_addr]) begin
          upd_status = STS_DUP;
        end
      end else if (!entry_valid[upd_addr]) begin
        upd_status = STS_MISSING;
      end else if (rd_data.side != upd_side) begin
        upd_status = STS_SIDE;
      end
    end
    if (upd_status == STS_OK && upd_seq != seq_last + 1'b1) begin
      upd_status = STS_GAP;
    end
  end

  assign upd_ok  = (upd_status == STS_OK);
  assign mem_we  = (state == ST_UPD) && out_free && upd_ok &&
                   (upd_kind == UPD_ADD || upd_kind == UPD_MODIFY);
  assign wr_data = '{side:  (upd_kind == UPD_ADD) ? upd_side : rd_data.side,
                     price: upd_price,
                     qty:   upd_qty};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[upd_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      seq_last    <= '0;
      entry_valid <= '0;
      msg_idx     <= '0;
      tick_cnt    <= '0;
      slot_cnt    <= '0;
    end else begin
      tick_cnt <= tick_next;
      slot_cnt <= slot_next;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_SNAPSHOT) begin
              msg_idx <= '0;
              state   <= ST_START;
            end else begin
              upd_seq      <= seq_num;
              upd_kind     <= update_kind;
              upd_side     <= side;
              upd_price    <= price;
              upd_qty      <= qty;
              upd_in_range <= in_range;
              upd_addr     <= in_addr;
              state        <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            res       <= '{msg_index: '0, msg_kind: MSG_STATUS, ticker: '0, order: '0,
                           side: 1'b0, price: '0, qty: '0, last_seq: upd_seq,
                           status: upd_status, last: 1'b1};
            seq_last  <= upd_seq;
            if (upd_ok && upd_kind == UPD_ADD) begin
              entry_valid[upd_addr] <= 1'b1;
            end
            if (upd_ok && upd_kind == UPD_CANCEL) begin
              entry_valid[upd_addr] <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_START: begin
          if (out_free) begin
            out_valid <= 1'b1;
            res       <= '{msg_index: msg_idx, msg_kind: MSG_START, ticker: '0, order: '0,
                           side: 1'b0, price: '0, qty: '0, last_seq: seq_last,
                           status: STS_OK, last: 1'b0};
            msg_idx   <= msg_idx + 1'b1;
            state     <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            res       <= '{msg_index: msg_idx, msg_kind: MSG_CLEAR, ticker: tick_cnt,
                           order: '0, side: 1'b0, price: '0, qty: '0, last_seq: '0,
                           status: STS_OK, last: 1'b0};
            msg_idx   <= msg_idx + 1'b1;
            state     <= ST_ORDER;
          end
        end
        ST_ORDER: begin
          if (entry_valid[scan_addr] && out_free) begin
            out_valid <= 1'b1;
            res       <= '{msg_index: msg_idx, msg_kind: MSG_ORDER, ticker: tick_cnt,
                           order: slot_cnt, side: rd_data.side, price: rd_data.price,
                           qty: rd_data.qty, last_seq: '0, status: STS_OK, last: 1'b0};
            msg_idx   <= msg_idx + 1'b1;
          end
          if (scan_adv && slot_end) begin
            state <= tick_end ? ST_END : ST_CLEAR;
          end
        end
        ST_END: begin
          if (out_free) begin
            out_valid <= 1'b1;
            res       <= '{msg_index: msg_idx, msg_kind: MSG_END, ticker: '0, order: '0,
                           side: 1'b0, price: '0, qty: '0, last_seq: seq_last,
                           status: STS_OK, last: 1'b1};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign msg_index  = res.msg_index;
  assign msg_kind   = res.msg_kind;
  assign out_ticker = res.ticker;
  assign out_order  = res.order;
  assign out_side   = res.side;
  assign out_price  = res.price;
  assign out_qty    = res.qty;
  assign last_seq   = res.last_seq;
  assign status     = res.status;
  assign last       = res.last;

endmodule

>>> hdl/otse_checker.sv
module otse_checker
  import otse_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                cmd,
  input logic [SEQ_W-1:0]    seq_num,
  input logic [1:0]          update_kind,
  input logic [TICKER_W-1:0] ticker,
  input logic [SLOT_W-1:0]   order_slot,
  input logic                side,
  input logic [PRICE_W-1:0]  price,
  input logic [QTY_W-1:0]    qty,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_W-1:0]    msg_index,
  input logic [2:0]          msg_kind,
  input logic [TICKER_W-1:0] out_ticker,
  input logic [SLOT_W-1:0]   out_order,
  input logic                out_side,
  input logic [PRICE_W-1:0]  out_price,
  input logic [QTY_W-1:0]    out_qty,
  input logic [SEQ_W-1:0]    last_seq,
  input logic [2:0]          status,
  input logic                last
);

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_kind == MSG_STATUS |-> last && msg_index == '0)
    else $error("status transfer not single");

  a_start_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_kind == MSG_START |-> !last && msg_index == '0)
    else $error("snapshot start misplaced");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> msg_kind == MSG_END || msg_kind == MSG_STATUS)
    else $error("last flag on wrong message");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(msg_kind) && $stable(msg_index))
    else $error("output dropped before transfer");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind order_table_snapshot_engine_top otse_checker u_otse_checker (.*);
